// ===== rtl/hmlv_pkg.sv =====
`timescale 1ns / 1ps
// shared types, character codes and helpers for the height map line validator
// no dependencies

package hmlv_pkg;

   localparam int POINT_W          = 13;
   localparam int MAX_POINTS_DEF   = 4096;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_X     = 8'h78;

   typedef enum logic [2:0] {
      PH_FRESH  = 3'd0,
      PH_SPACES = 3'd1,
      PH_DIGITS = 3'd2,
      PH_COMMA  = 3'd3,
      PH_ZERO   = 3'd4,
      PH_HEX    = 3'd5
   } phase_type;

   typedef struct packed {
      logic               line_valid;
      logic [POINT_W-1:0] point_count;
   } line_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF_HEX)) ||
             ((c >= CH_UA) && (c <= CH_UF));
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_NUL);
   endfunction

endpackage

// ===== rtl/hmlv_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and line results
// depends on hmlv_pkg

interface hmlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       new_map;

   modport source (output valid, output text_byte, output new_map, input ready);
   modport sink   (input valid, input text_byte, input new_map, output ready);
endinterface

interface hmlv_rsp_if
   import hmlv_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               line_valid;
   logic [POINT_W-1:0] point_count;

   modport source (output valid, output line_valid, output point_count, input ready);
   modport sink   (input valid, input line_valid, input point_count, output ready);
endinterface

// ===== rtl/hmlv_scan.sv =====
`timescale 1ns / 1ps
// line scanner: phase, point counter, expected width and error flag
// depends on hmlv_pkg

module hmlv_scan
   import hmlv_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      text_byte,
   input  logic            new_map,
   output line_result_type result
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   phase_type        phase_ff, phase_in, cur_phase;
   logic [CNT_W-1:0] points_ff, points_in, cur_points;
   logic [CNT_W-1:0] expected_ff, expected_in, cur_expected;
   logic             failed_ff, failed_in, cur_failed;

   logic             cnt_full;
   logic [CNT_W-1:0] cnt_next;
   logic             term_failed;
   logic [CNT_W-1:0] term_points;
   logic             term_valid;

   // a new map restarts from reset state before this byte is handled
   always_comb begin
      cur_phase    = new_map ? PH_FRESH : phase_ff;
      cur_points   = new_map ? '0 : points_ff;
      cur_expected = new_map ? '0 : expected_ff;
      cur_failed   = new_map ? 1'b0 : failed_ff;
      cnt_full     = cur_points >= CNT_MAX;
      cnt_next     = cur_points + CNT_W'(1);
   end

   // line end: close any open point, then judge the line
   always_comb begin
      term_failed = cur_failed;
      term_points = cur_points;
      if (!cur_failed) begin
         if (cur_phase inside {PH_SPACES, PH_DIGITS, PH_HEX}) begin
            if (cnt_full) begin
               term_failed = 1'b1;
            end else begin
               term_points = cnt_next;
            end
         end else if (cur_phase inside {PH_COMMA, PH_ZERO}) begin
            term_failed = 1'b1;
         end
      end
      term_valid = !term_failed &&
                   ((cur_expected == '0) || (term_points == cur_expected));
   end

   always_comb begin
      result.line_valid  = term_valid;
      result.point_count = POINT_W'(term_points);
   end

   always_comb begin
      phase_in    = cur_phase;
      points_in   = cur_points;
      expected_in = cur_expected;
      failed_in   = cur_failed;
      if (is_term(text_byte)) begin
         phase_in  = PH_FRESH;
         points_in = '0;
         failed_in = 1'b0;
         if (term_valid && (cur_expected == '0)) begin
            expected_in = term_points;
         end
      end else if (!cur_failed) begin
         case (cur_phase)
            PH_FRESH, PH_SPACES: begin
               if (text_byte == CH_SPACE) begin
                  phase_in = PH_SPACES;
               end else if ((text_byte == CH_MINUS) || (text_byte == CH_PLUS) ||
                            is_digit(text_byte)) begin
                  phase_in = PH_DIGITS;
               end else if (text_byte == CH_COMMA) begin
                  phase_in = PH_COMMA;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (text_byte == CH_SPACE) begin
                  phase_in = PH_FRESH;
                  if (cnt_full) begin
                     failed_in = 1'b1;
                  end else begin
                     points_in = cnt_next;
                  end
               end else if (text_byte == CH_COMMA) begin
                  phase_in = PH_COMMA;
               end else if (!is_digit(text_byte)) begin
                  failed_in = 1'b1;
               end
            end
            PH_COMMA: begin
               if (text_byte == CH_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_ZERO: begin
               if (text_byte == CH_X) begin
                  phase_in = PH_HEX;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_HEX: begin
               if (text_byte == CH_SPACE) begin
                  phase_in = PH_FRESH;
                  if (cnt_full) begin
                     failed_in = 1'b1;
                  end else begin
                     points_in = cnt_next;
                  end
               end else if (!is_hex(text_byte)) begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               phase_in  = PH_FRESH;
               failed_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FRESH;
         points_ff   <= '0;
         expected_ff <= '0;
         failed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         points_ff   <= points_in;
         expected_ff <= expected_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

// ===== rtl/height_map_line_validator.sv =====
`timescale 1ns / 1ps
// top level of the height map line validator: request register, scanner, result register
// depends on hmlv_pkg, hmlv_if and hmlv_scan
//
//   channel  | direction | payload                   | when
//   ---------+-----------+---------------------------+-------------------------------
//   req_if   | in        | text_byte, new_map        | one text byte per request
//   rsp_if   | out       | line_valid, point_count   | one result per newline or NUL
//
// one request per cycle unless a line end waits on a stalled result; a line end passes the
// request register, then the result register. the scanner state update is the only loop.
// synchronous active-high reset clears the scanner and both valid flags.
// a stalled result holds only line-ending requests; other bytes still pass through.

module height_map_line_validator
   import hmlv_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input logic      clock,
   input logic      reset,
   hmlv_req_if.sink   req_if,
   hmlv_rsp_if.source rsp_if
);

   logic            req_valid_ff;
   logic [7:0]      req_byte_ff;
   logic            req_new_map_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   line_result_type rsp_data_ff;
   line_result_type scan_result;
   logic            term;
   logic            advance;

   assign term    = is_term(req_byte_ff);
   // a line end needs room in the result register, other bytes never wait
   assign advance = req_valid_ff && (!term || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   hmlv_scan #(
      .MAX_POINTS (MAX_POINTS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_byte (req_byte_ff),
      .new_map   (req_new_map_ff),
      .result    (scan_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (advance && term) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            req_valid_ff <= req_if.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_byte_ff    <= req_if.text_byte;
         req_new_map_ff <= req_if.new_map;
      end
      if (advance && term) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.line_valid  = rsp_data_ff.line_valid;
   assign rsp_if.point_count = rsp_data_ff.point_count;

endmodule

// ===== sim/height_map_line_validator_checker.sv =====
`timescale 1ns / 1ps
// line result checker for the height map line validator testbench
// watches both channels, predicts every line result and compares; needs hmlv_pkg and hmlv_if

module height_map_line_validator_checker
   import hmlv_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hmlv_req_if         req_if,
   hmlv_rsp_if         rsp_if,
   output int unsigned error_count,
   output int unsigned lines_pending,
   output int unsigned lines_checked,
   output int unsigned lines_valid
);

   phase_type          scan_phase;
   logic [POINT_W-1:0] points_so_far;
   logic [POINT_W-1:0] map_width;
   logic               line_failed;
   line_result_type    lines_due[$];

   function automatic logic is_dec_char(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic is_hex_char(input logic [7:0] ch);
      return is_dec_char(ch) || ((ch >= CH_LA) && (ch <= CH_LF_HEX)) ||
             ((ch >= CH_UA) && (ch <= CH_UF));
   endfunction

   task automatic bump_point();
      // past the limit the count sticks and the line is marked bad
      if (int'(points_so_far) >= MAX_POINTS)
         line_failed = 1'b1;
      else
         points_so_far = points_so_far + 1'b1;
   endtask

   task automatic clear_map();
      scan_phase    = PH_FRESH;
      points_so_far = '0;
      map_width     = '0;
      line_failed   = 1'b0;
   endtask

   task automatic scan_request(input logic [7:0] ch, input logic fresh_map);
      line_result_type res;
      if (fresh_map)
         clear_map();
      if ((ch == CH_LF) || (ch == CH_NUL)) begin
         if (!line_failed) begin
            case (scan_phase)
               PH_SPACES, PH_DIGITS, PH_HEX: bump_point();
               PH_COMMA, PH_ZERO: line_failed = 1'b1;
               default: ;
            endcase
         end
         res.line_valid  = !line_failed && ((map_width == '0) || (points_so_far == map_width));
         res.point_count = points_so_far;
         // an empty valid line leaves the width unset, since it stays zero
         if (res.line_valid && (map_width == '0))
            map_width = points_so_far;
         lines_due.push_back(res);
         scan_phase    = PH_FRESH;
         points_so_far = '0;
         line_failed   = 1'b0;
      end else if (!line_failed) begin
         case (scan_phase)
            PH_FRESH, PH_SPACES: begin
               if (ch == CH_SPACE)
                  scan_phase = PH_SPACES;
               else if ((ch == CH_MINUS) || (ch == CH_PLUS) || is_dec_char(ch))
                  scan_phase = PH_DIGITS;
               else if (ch == CH_COMMA)
                  scan_phase = PH_COMMA;
               else
                  line_failed = 1'b1;
            end
            PH_DIGITS: begin
               if (ch == CH_SPACE) begin
                  bump_point();
                  scan_phase = PH_FRESH;
               end else if (ch == CH_COMMA) begin
                  scan_phase = PH_COMMA;
               end else if (!is_dec_char(ch)) begin
                  line_failed = 1'b1;
               end
            end
            PH_COMMA: begin
               if (ch == CH_ZERO)
                  scan_phase = PH_ZERO;
               else
                  line_failed = 1'b1;
            end
            PH_ZERO: begin
               if (ch == CH_X)
                  scan_phase = PH_HEX;
               else
                  line_failed = 1'b1;
            end
            PH_HEX: begin
               if (ch == CH_SPACE) begin
                  bump_point();
                  scan_phase = PH_FRESH;
               end else if (!is_hex_char(ch)) begin
                  line_failed = 1'b1;
               end
            end
            default: begin
               scan_phase  = PH_FRESH;
               line_failed = 1'b1;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         clear_map();
         lines_due.delete();
         error_count   = 0;
         lines_checked = 0;
         lines_valid   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (lines_due.size() == 0) begin
               $error("unexpected line result: line_valid %0b point_count %0d",
                      rsp_if.line_valid, rsp_if.point_count);
               error_count++;
            end else begin
               want = lines_due.pop_front();
               lines_checked++;
               if (want.line_valid)
                  lines_valid++;
               if (rsp_if.line_valid !== want.line_valid) begin
                  $error("line_valid: expected %0b, actual %0b",
                         want.line_valid, rsp_if.line_valid);
                  error_count++;
               end
               if (rsp_if.point_count !== want.point_count) begin
                  $error("point_count: expected %0d, actual %0d",
                         want.point_count, rsp_if.point_count);
                  error_count++;
               end
            end
         end
         // a result passes the request and result registers after its request, so compare before predicting
         if (req_if.valid && req_if.ready)
            scan_request(req_if.text_byte, req_if.new_map);
      end
      lines_pending = lines_due.size();
   end

endmodule

// ===== sim/height_map_line_validator_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the height map line validator: clock, reset, map text stimulus, verdict
// needs hmlv_pkg, hmlv_if, the block and height_map_line_validator_checker

module height_map_line_validator_tb;
   import hmlv_pkg::*;

   localparam int MAX_POINTS  = MAX_POINTS_DEF;
   localparam int STAGE_BYTES = 105;
   localparam int STAGE_LINES = 6;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_text_byte = CH_NUL;
   logic       req_new_map   = 1'b0;
   logic       rsp_ready     = 1'b0;

   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 66;
   int unsigned requests_sent = 0;
   int unsigned map_cols      = 3;
   int unsigned error_count, lines_pending, lines_checked, lines_valid;
   logic [7:0]  line_text[$];
   string       hex_digits = "0123456789abcdefABCDEF";

   hmlv_req_if req_if();
   hmlv_rsp_if rsp_if();

   assign req_if.valid     = req_valid;
   assign req_if.text_byte = req_text_byte;
   assign req_if.new_map   = req_new_map;
   assign rsp_if.ready     = rsp_ready;

   height_map_line_validator #(.MAX_POINTS(MAX_POINTS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   height_map_line_validator_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .error_count   (error_count),
      .lines_pending (lines_pending),
      .lines_checked (lines_checked),
      .lines_valid   (lines_valid)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5_000_000;
      $display("height_map_line_validator_tb: done, errors");
      $finish;
   end

   task automatic send_byte(input logic [7:0] ch, input logic fresh_map);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      req_new_map   <= fresh_map;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_line(input logic fresh_map);
      foreach (line_text[i])
         send_byte(line_text[i], fresh_map && (i == 0));
   endtask

   task automatic send_text(input string s, input logic [7:0] term, input logic fresh_map);
      line_text = {};
      for (int i = 0; i < s.len(); i++)
         line_text.push_back(s[i]);
      line_text.push_back(term);
      send_line(fresh_map);
   endtask

   // sender holds off until every outstanding line result has been checked
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_pending != 0)
         @(posedge clock);
   endtask

   task automatic add_point();
      int unsigned sign_pick, ndig;
      bit          with_hex;
      sign_pick = $urandom_range(2);
      with_hex  = ($urandom_range(3) == 0);
      ndig      = $urandom_range(4);
      if ((sign_pick == 0) && !with_hex && (ndig == 0))
         ndig = 1;
      if (sign_pick == 1)
         line_text.push_back(CH_MINUS);
      else if (sign_pick == 2)
         line_text.push_back(CH_PLUS);
      repeat (ndig)
         line_text.push_back(CH_ZERO + 8'($urandom_range(9)));
      if (with_hex) begin
         line_text.push_back(CH_COMMA);
         line_text.push_back(CH_ZERO);
         line_text.push_back(CH_X);
         repeat ($urandom_range(3))
            line_text.push_back(hex_digits[$urandom_range(21)]);
      end
   endtask

   // mostly well formed lines, some with one byte corrupted, some pure noise
   task automatic build_random_line();
      int unsigned kind, npoints;
      kind = $urandom_range(99);
      line_text = {};
      if (kind < 15) begin
         repeat ($urandom_range(1, 12))
            line_text.push_back(8'($urandom_range(255)));
      end else begin
         npoints = ($urandom_range(3) == 0) ? $urandom_range(map_cols + 1) : map_cols;
         if ($urandom_range(9) == 0)
            line_text.push_back(CH_SPACE);
         for (int i = 0; i < npoints; i++) begin
            if (i > 0)
               line_text.push_back(CH_SPACE);
            add_point();
         end
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
               line_text.push_back(CH_SPACE);
         if ((kind < 30) && (line_text.size() > 0))
            line_text[$urandom_range(line_text.size() - 1)] = 8'($urandom_range(255));
      end
      line_text.push_back(($urandom_range(6) == 0) ? CH_NUL : CH_LF);
   endtask

   initial begin
      int unsigned stage_bytes, stage_lines;
      logic        fresh;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed lines: signs, hex suffixes, both terminators, malformed endings
      send_text("1 -2 +3", CH_LF, 1'b1);
      send_text("9 0,0xfF 7", CH_NUL, 1'b0);
      send_text("- + ,0x", CH_LF, 1'b0);
      send_text("1 2  ", CH_LF, 1'b0);
      send_text("1 2", CH_LF, 1'b0);
      send_text("1,0X2", CH_LF, 1'b0);
      send_text("1,", CH_LF, 1'b0);
      send_text("1,0", CH_NUL, 1'b0);
      send_text("5 a 3", CH_LF, 1'b0);
      send_text("0,0xAF09ag", CH_LF, 1'b0);
      send_text("9/", CH_LF, 1'b0);
      send_text("", CH_LF, 1'b1);
      send_text("   ", CH_LF, 1'b0);
      line_text = '{8'h31, 8'hff, 8'h80, CH_LF};
      send_line(1'b0);

      for (int stage = 0; stage < 3; stage++) begin
         stage_bytes = 0;
         stage_lines = 0;
         case (stage)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 66;
            end
            1: begin
               drain_results();
               send_idle_pct = 66;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while ((stage_bytes < STAGE_BYTES) || (stage_lines < STAGE_LINES)) begin
            fresh = ((stage == 0) && (stage_lines == 0)) || ($urandom_range(11) == 0);
            if (fresh)
               map_cols = $urandom_range(1, 6);
            build_random_line();
            stage_bytes += line_text.size();
            stage_lines++;
            send_line(fresh);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("run covered %0d requests and %0d line results, %0d of them valid",
               requests_sent, lines_checked, lines_valid);
      $display("incl. directed malformed lines and three sender/receiver stall mixes");
      if (error_count == 0)
         $display("height_map_line_validator_tb: done, clean");
      else
         $display("height_map_line_validator_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hmlv_pkg.sv
rtl/hmlv_if.sv
rtl/hmlv_scan.sv
rtl/height_map_line_validator.sv
sim/height_map_line_validator_checker.sv
sim/height_map_line_validator_tb.sv
